// ===== src/lwe_pkg.sv =====
// ----------------------------------------------------------------------------
// lwe_pkg: shared constants and helpers of the long word extractor
// Byte and line widths, whitespace codes and the default word store depth.
// ----------------------------------------------------------------------------
package lwe_pkg;

   localparam int unsigned LWE_MAX_WORD = 32;
   localparam int unsigned LWE_BYTE_W   = 8;
   localparam int unsigned LWE_LINE_W   = 32;

   localparam logic [LWE_BYTE_W-1:0] LWE_NUL     = 8'h00;
   localparam logic [LWE_BYTE_W-1:0] LWE_TAB     = 8'h09;
   localparam logic [LWE_BYTE_W-1:0] LWE_NEWLINE = 8'h0A;
   localparam logic [LWE_BYTE_W-1:0] LWE_CR      = 8'h0D;
   localparam logic [LWE_BYTE_W-1:0] LWE_SPACE   = 8'h20;
   localparam logic [LWE_BYTE_W-1:0] LWE_LEN_SAT = 8'hFF;

   // C-locale whitespace: space, and tab through carriage return
   function automatic logic is_blank(input logic [LWE_BYTE_W-1:0] b);
      return (b == LWE_SPACE) || ((b >= LWE_TAB) && (b <= LWE_CR));
   endfunction

endpackage

// ===== src/lwe_req_if.sv =====
// ----------------------------------------------------------------------------
// lwe_req_if: text byte channel
// Valid/ready channel carrying one text byte and the end-of-stream flag.
// ----------------------------------------------------------------------------
interface lwe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_stream;

   modport source (output valid, output in_byte, output end_of_stream, input ready);
   modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// ===== src/lwe_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lwe_rsp_if: record byte channel
// Valid/ready channel carrying one record byte and its last marker.
// ----------------------------------------------------------------------------
interface lwe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== src/long_word_extractor.sv =====
// A qualifying word's record starts once the closing whitespace or end of stream is
//   taken; each record byte passes the fetch stage and then the output register.
// Throughput: one byte per cycle while scanning; a record of stored bytes plus five
//   leaves at one byte per cycle while the receiver is ready, and input stalls meanwhile.
// Reset: synchronous, active high; clears counters, lines to one, min_length to 0;
//   the word RAM is not cleared, as only bytes of the current word are read.
// ----------------------------------------------------------------------------
// long_word_extractor: top level
// Reports words of at least min_length bytes with their starting line.
// ----------------------------------------------------------------------------
module long_word_extractor #(
   parameter int unsigned MAX_WORD = lwe_pkg::LWE_MAX_WORD
) (
   input  logic                           clock,
   input  logic                           reset,
   lwe_req_if.sink                        req_bus,
   lwe_rsp_if.source                      rsp_bus,
   input  logic                           csr_wr_en,
   input  logic [lwe_pkg::LWE_BYTE_W-1:0] csr_wr_data
);
   import lwe_pkg::*;

   localparam int unsigned AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [LWE_BYTE_W-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   logic [LWE_BYTE_W-1:0] ram_rd_data;

   // scanner and record sequencer
   lwe_ctrl #(
      .MAX_WORD (MAX_WORD),
      .AW       (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // word store
   lwe_ram #(
      .WIDTH (LWE_BYTE_W),
      .DEPTH (MAX_WORD),
      .AW    (AW)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== src/lwe_ram.sv =====
// ----------------------------------------------------------------------------
// lwe_ram: generic simple dual-port RAM
// One write port, one read port with enable and a registered read.
// ----------------------------------------------------------------------------
module lwe_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, and register the read data; hold it while no read is issued
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lwe_ctrl.sv =====
// ----------------------------------------------------------------------------
// lwe_ctrl: scanner and record sequencer
// Scans bytes into the word RAM, then reads the word back and appends the
// terminator and the big-endian start line through a one-entry fetch stage.
// ----------------------------------------------------------------------------
module lwe_ctrl #(
   parameter int unsigned MAX_WORD = lwe_pkg::LWE_MAX_WORD,
   parameter int unsigned AW       = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   lwe_req_if.sink                      req_bus,
   lwe_rsp_if.source                    rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [lwe_pkg::LWE_BYTE_W-1:0] csr_wr_data,
   output logic                         ram_wr_en,
   output logic [AW-1:0]                ram_wr_addr,
   output logic [lwe_pkg::LWE_BYTE_W-1:0] ram_wr_data,
   output logic                         ram_rd_en,
   output logic [AW-1:0]                ram_rd_addr,
   input  logic [lwe_pkg::LWE_BYTE_W-1:0] ram_rd_data
);
   import lwe_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_WORD + 6);
   localparam logic [LWE_BYTE_W-1:0] MAX_LEN = LWE_BYTE_W'(MAX_WORD);
   localparam logic [POS_W-1:0]      MAX_POS = POS_W'(MAX_WORD);
   localparam logic [POS_W-1:0]      TAIL_LEN = POS_W'(5);

   // offsets into the record tail behind the stored word bytes
   localparam logic [2:0] TAIL_NUL = 3'd0;
   localparam logic [2:0] TAIL_B3  = 3'd1;
   localparam logic [2:0] TAIL_B2  = 3'd2;
   localparam logic [2:0] TAIL_B1  = 3'd3;
   localparam logic [2:0] TAIL_B0  = 3'd4;

   typedef enum logic {
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [LWE_BYTE_W-1:0]   len_ff, len_in;
   logic [LWE_LINE_W-1:0]   line_ff, line_in;
   logic [LWE_LINE_W-1:0]   start_ff, start_in;
   logic [LWE_BYTE_W-1:0]   min_len_ff, min_len_in;
   logic [POS_W-1:0]        stored_ff, stored_in;
   logic [LWE_LINE_W-1:0]   emit_line_ff, emit_line_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    fv_ff, fv_in;
   logic [POS_W-1:0]        fpos_ff, fpos_in;
   logic                    out_valid_ff, out_valid_in;
   logic [LWE_BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                    out_last_ff, out_last_in;

   logic                    req_acc;
   logic                    blank;
   logic                    qualify;
   logic [POS_W-1:0]        stored_w;
   logic [POS_W-1:0]        total;
   logic                    out_free;
   logic                    consume;
   logic                    fetch;
   logic [POS_W-1:0]        tail_diff;
   logic [2:0]              tail_off;
   logic [LWE_BYTE_W-1:0]   tail_byte;
   logic [LWE_BYTE_W-1:0]   fetch_byte;

   // take bytes only while scanning
   assign req_bus.ready = (state_ff == ST_SCAN);
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign blank         = is_blank(req_bus.in_byte);

   // word qualifies if nonempty and long enough
   assign qualify  = (len_ff != '0) && (len_ff >= min_len_ff);
   assign stored_w = (len_ff < MAX_LEN) ? POS_W'(len_ff) : MAX_POS;
   assign total    = stored_ff + TAIL_LEN;

   // fetch stage advances when the output register is free
   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign consume  = fv_ff && out_free;
   assign fetch    = (state_ff == ST_EMIT) && (pos_ff != total) && (!fv_ff || out_free);

   // store word bytes; writes and reads never overlap, the FSM keeps them apart
   assign ram_wr_en   = req_acc && !req_bus.end_of_stream && !blank && (len_ff < MAX_LEN);
   assign ram_wr_addr = len_ff[AW-1:0];
   assign ram_wr_data = req_bus.in_byte;
   assign ram_rd_en   = fetch && (pos_ff < stored_ff);
   assign ram_rd_addr = pos_ff[AW-1:0];

   // select the tail byte for the fetched position
   assign tail_diff = fpos_ff - stored_ff;
   assign tail_off  = tail_diff[2:0];

   always_comb begin
      case (tail_off)
         TAIL_NUL: tail_byte = LWE_NUL;
         TAIL_B3:  tail_byte = emit_line_ff[31:24];
         TAIL_B2:  tail_byte = emit_line_ff[23:16];
         TAIL_B1:  tail_byte = emit_line_ff[15:8];
         TAIL_B0:  tail_byte = emit_line_ff[7:0];
         default:  tail_byte = LWE_NUL;
      endcase
   end

   assign fetch_byte = (fpos_ff < stored_ff) ? ram_rd_data : tail_byte;

   // next state
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      line_in      = line_ff;
      start_in     = start_ff;
      min_len_in   = min_len_ff;
      stored_in    = stored_ff;
      emit_line_in = emit_line_ff;
      pos_in       = pos_ff;
      fv_in        = fv_ff;
      fpos_in      = fpos_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;

      if (csr_wr_en) begin
         min_len_in = csr_wr_data;
      end

      // output register: load from the fetch stage, or drop after transfer
      if (consume) begin
         out_valid_in = 1'b1;
         out_byte_in  = fetch_byte;
         out_last_in  = (tail_off == TAIL_B0) && (fpos_ff >= stored_ff);
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      // fetch stage: issue the next position, or drain
      if (fetch) begin
         fv_in   = 1'b1;
         fpos_in = pos_ff;
         pos_in  = pos_ff + 1'b1;
      end else if (consume) begin
         fv_in = 1'b0;
      end

      unique case (state_ff)
         ST_SCAN: begin
            if (req_acc) begin
               if (req_bus.end_of_stream || blank) begin
                  if (qualify) begin
                     stored_in    = stored_w;
                     emit_line_in = start_ff;
                     pos_in       = '0;
                     state_in     = ST_EMIT;
                  end
                  len_in = '0;
                  if (req_bus.end_of_stream) begin
                     line_in  = LWE_LINE_W'(1);
                     start_in = LWE_LINE_W'(1);
                  end else if (req_bus.in_byte == LWE_NEWLINE) begin
                     line_in = line_ff + 1'b1;
                  end
               end else begin
                  if (len_ff == '0) begin
                     start_in = line_ff;
                  end
                  if (len_ff != LWE_LEN_SAT) begin
                     len_in = len_ff + 1'b1;
                  end
               end
            end
         end
         ST_EMIT: begin
            // final byte leaves the fetch stage
            if (consume && (pos_ff == total)) begin
               state_in = ST_SCAN;
            end
         end
         default: state_in = ST_SCAN;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SCAN;
         len_ff       <= '0;
         line_ff      <= LWE_LINE_W'(1);
         start_ff     <= LWE_LINE_W'(1);
         min_len_ff   <= '0;
         pos_ff       <= '0;
         fv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         line_ff      <= line_in;
         start_ff     <= start_in;
         min_len_ff   <= min_len_in;
         pos_ff       <= pos_in;
         fv_ff        <= fv_in;
         out_valid_ff <= out_valid_in;
      end
      stored_ff    <= stored_in;
      emit_line_ff <= emit_line_in;
      fpos_ff      <= fpos_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.out_byte = out_byte_ff;
   assign rsp_bus.last     = out_last_ff;

   // checks
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("word RAM written and read in one cycle");

   a_fetch_in_range: assert property (@(posedge clock) disable iff (reset)
      fv_ff |-> (fpos_ff < total))
      else $error("fetch stage beyond record end");

   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !fv_ff)
      else $error("fetch stage busy while scanning");

   a_emit_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && (state_in == ST_EMIT) |=> (pos_ff == '0) && !fv_ff)
      else $error("record did not start at position zero");

endmodule
